>>> hw/rtl/nbck_pkg.sv
// nbck_pkg: shared types and constants of the n-best candidate keeper
// no dependencies; imported by every module of the block
package nbck_pkg;

  // default build sizes
  localparam int unsigned MaxKeepDefault   = 16;
  localparam int unsigned QuestionBitsDflt = 10;

  // fixed field widths
  localparam int unsigned KeepW  = 5;
  localparam int unsigned GainW  = 32;
  localparam int unsigned WordW  = 32;
  localparam int unsigned RidxW  = 4;
  localparam int unsigned ModeW  = 2;

  // item modes
  localparam logic [ModeW-1:0] ModePush  = 2'd0;
  localparam logic [ModeW-1:0] ModeClear = 2'd1;
  localparam logic [ModeW-1:0] ModeRead  = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAST_CHK,
    ST_SINK_RD,
    ST_SINK_CMP,
    ST_READ_WAIT,
    ST_DONE
  } nbck_state_e;

endpackage

>>> hw/rtl/nbck_entry_ram.sv
// nbck_entry_ram: list storage, one write port and one registered read port
// depends on nbck_pkg for the default sizes; sized by parameters
module nbck_entry_ram
  import nbck_pkg::*;
#(
  parameter int unsigned DEPTH  = MaxKeepDefault,
  parameter int unsigned DATA_W = 7 * WordW + QuestionBitsDflt,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/nbck_gain_cmp.sv
// nbck_gain_cmp: shared gain comparator used for the full-list check and each sink step
// depends on nbck_pkg for the gain width
module nbck_gain_cmp
  import nbck_pkg::*;
(
  input  logic [GainW-1:0] entry_gain_i,
  input  logic [GainW-1:0] cand_gain_i,
  output logic             cand_wins_o
);

  // candidate moves past an entry only on strictly greater gain
  assign cand_wins_o = (entry_gain_i < cand_gain_i);

endmodule

>>> hw/rtl/n_best_candidate_keeper.sv
// n_best_candidate_keeper: top level, sequencer and result register
// depends on nbck_pkg, nbck_entry_ram and nbck_gain_cmp
//
// Usage:
// - input channel (in_valid_i / in_stall_o) carries one item: mode plus a
//   candidate (push), nothing (clear) or a rank (read). in_stall_o is high
//   whenever the sequencer is busy with an item.
// - output channel (out_valid_o / out_stall_i) returns exactly one result
//   item per input item from a result register; it holds while stalled and
//   the next input item is taken only after the result is delivered.
// - keep_count is written through cfg_we_i / cfg_wdata_i, by the user only while
//   idle, which the block itself does not enforce; every write also empties the list.
// Steps from accept to result valid:
// - clear and no-op go straight to the result; read waits on the registered memory read
// - push into a list that is not full: a read step and a compare step per entry passed,
//   then the candidate is written, at rank 0 from the read step, otherwise from the compare
// - push into a full list: a check against the last entry first, which rejects or replaces it
// The next item is taken the cycle after the result is delivered.
// Reset empties the list and sets keep_count to 1; the memory is not
// cleared since only ranks below the held count ever reach a result or a compare.
module n_best_candidate_keeper
  import nbck_pkg::*;
#(
  parameter int unsigned MAX_KEEP            = MaxKeepDefault,
  parameter int unsigned QUESTION_INDEX_BITS = QuestionBitsDflt,
  parameter int unsigned CNT_W               = $clog2(MAX_KEEP + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [KeepW-1:0]               cfg_wdata_i,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [ModeW-1:0]               mode_i,
  input  logic [GainW-1:0]               gain_i,
  input  logic [QUESTION_INDEX_BITS-1:0] question_index_i,
  input  logic [WordW-1:0]               left_examples_i,
  input  logic [WordW-1:0]               right_examples_i,
  input  logic [WordW-1:0]               left_observations_i,
  input  logic [WordW-1:0]               right_observations_i,
  input  logic [WordW-1:0]               left_score_word_i,
  input  logic [WordW-1:0]               right_score_word_i,
  input  logic [RidxW-1:0]               read_index_i,
  // output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           accepted_o,
  output logic [CNT_W-1:0]               held_count_o,
  output logic                           entry_valid_o,
  output logic [GainW-1:0]               out_gain_o,
  output logic [QUESTION_INDEX_BITS-1:0] out_question_index_o,
  output logic [WordW-1:0]               out_left_examples_o,
  output logic [WordW-1:0]               out_right_examples_o,
  output logic [WordW-1:0]               out_left_observations_o,
  output logic [WordW-1:0]               out_right_observations_o,
  output logic [WordW-1:0]               out_left_score_word_o,
  output logic [WordW-1:0]               out_right_score_word_o
);

  localparam int unsigned AW     = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int unsigned DATA_W = 7 * WordW + QUESTION_INDEX_BITS;
  localparam int unsigned CW     = (CNT_W > KeepW) ? CNT_W : KeepW;
  localparam int unsigned IW     = (CNT_W > RidxW) ? CNT_W : RidxW;

  nbck_state_e state_q, state_d;

  logic [KeepW-1:0]  keep_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  pos_q, pos_d;
  logic [GainW-1:0]  cand_gain_q, cand_gain_d;
  logic [DATA_W-1:0] cand_q, cand_d;
  logic              hit_q, hit_d;
  logic              accepted_q, accepted_d;
  logic              valid_q, valid_d;
  logic [DATA_W-1:0] res_q, res_d;

  logic              in_acc;
  logic              out_acc;
  logic [CW-1:0]     cap_w;
  logic [CNT_W-1:0]  cap;
  logic [CNT_W-1:0]  cap_m1;
  logic [CNT_W-1:0]  pos_m1;
  logic              full;
  logic [IW-1:0]     ridx_w;
  logic              read_hit;
  logic [DATA_W-1:0] in_entry;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;
  logic              cand_wins;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // capacity in effect: keep_count limited to 1..MAX_KEEP
  always_comb begin
    if (keep_q == '0) begin
      cap_w = CW'(1);
    end else if (CW'(keep_q) > CW'(MAX_KEEP)) begin
      cap_w = CW'(MAX_KEEP);
    end else begin
      cap_w = CW'(keep_q);
    end
  end

  assign cap    = cap_w[CNT_W-1:0];
  assign cap_m1 = cap - CNT_W'(1);
  assign pos_m1 = pos_q - CNT_W'(1);
  assign full   = (count_q >= cap);

  // read rank check against the held count
  assign ridx_w   = IW'(read_index_i);
  assign read_hit = (ridx_w < IW'(count_q));

  // entry packing, gain in the low bits
  assign in_entry = {right_score_word_i, left_score_word_i,
                     right_observations_i, left_observations_i,
                     right_examples_i, left_examples_i,
                     question_index_i, gain_i};

  // entry storage
  nbck_entry_ram #(
    .DEPTH  (MAX_KEEP),
    .DATA_W (DATA_W),
    .ADDR_W (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // shared comparator: stored entry gain against candidate gain
  nbck_gain_cmp u_cmp (
    .entry_gain_i (ram_rdata[GainW-1:0]),
    .cand_gain_i  (cand_gain_q),
    .cand_wins_o  (cand_wins)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (mode_i == ModePush) begin
            state_d = full ? ST_LAST_CHK : ST_SINK_RD;
          end else if (mode_i == ModeRead) begin
            state_d = ST_READ_WAIT;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_LAST_CHK: begin
        state_d = cand_wins ? ST_SINK_RD : ST_DONE;
      end
      ST_SINK_RD: begin
        state_d = (pos_q == '0) ? ST_DONE : ST_SINK_CMP;
      end
      ST_SINK_CMP: begin
        state_d = cand_wins ? ST_SINK_RD : ST_DONE;
      end
      ST_READ_WAIT: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_acc) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // datapath control and register next values
  always_comb begin
    count_d     = count_q;
    pos_d       = pos_q;
    cand_gain_d = cand_gain_q;
    cand_d      = cand_q;
    hit_d       = hit_q;
    accepted_d  = accepted_q;
    valid_d     = valid_q;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_waddr   = pos_q[AW-1:0];
    ram_wdata   = cand_q;
    ram_raddr   = pos_m1[AW-1:0];
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cand_gain_d = gain_i;
          cand_d      = in_entry;
          accepted_d  = 1'b0;
          valid_d     = 1'b0;
          res_d       = '0;
          hit_d       = read_hit;
          if (mode_i == ModePush) begin
            if (full) begin
              ram_raddr = cap_m1[AW-1:0];
            end else begin
              pos_d   = count_q;
              count_d = count_q + CNT_W'(1);
            end
          end else if (mode_i == ModeClear) begin
            count_d = '0;
          end else if (mode_i == ModeRead) begin
            ram_raddr = ridx_w[AW-1:0];
          end
        end
      end
      ST_LAST_CHK: begin
        // full list: replace last entry only on strictly greater gain
        if (cand_wins) begin
          pos_d = cap_m1;
        end
      end
      ST_SINK_RD: begin
        if (pos_q == '0) begin
          ram_we     = 1'b1;
          accepted_d = 1'b1;
        end
      end
      ST_SINK_CMP: begin
        ram_we = 1'b1;
        if (cand_wins) begin
          // move the smaller entry down one rank
          ram_wdata = ram_rdata;
          pos_d     = pos_m1;
        end else begin
          accepted_d = 1'b1;
        end
      end
      ST_READ_WAIT: begin
        valid_d = hit_q;
        res_d   = hit_q ? ram_rdata : '0;
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      keep_q  <= KeepW'(1);
      count_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        keep_q  <= cfg_wdata_i;
        count_q <= '0;
      end else begin
        count_q <= count_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    cand_gain_q <= cand_gain_d;
    cand_q      <= cand_d;
    hit_q       <= hit_d;
    accepted_q  <= accepted_d;
    valid_q     <= valid_d;
    res_q       <= res_d;
  end

  // ports
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_DONE);

  assign accepted_o               = accepted_q;
  assign held_count_o             = count_q;
  assign entry_valid_o            = valid_q;
  assign out_gain_o               = res_q[GainW-1:0];
  assign out_question_index_o     = res_q[GainW +: QUESTION_INDEX_BITS];
  assign out_left_examples_o      = res_q[GainW + QUESTION_INDEX_BITS +: WordW];
  assign out_right_examples_o     = res_q[GainW + QUESTION_INDEX_BITS + WordW +: WordW];
  assign out_left_observations_o  = res_q[GainW + QUESTION_INDEX_BITS + 2*WordW +: WordW];
  assign out_right_observations_o = res_q[GainW + QUESTION_INDEX_BITS + 3*WordW +: WordW];
  assign out_left_score_word_o    = res_q[GainW + QUESTION_INDEX_BITS + 4*WordW +: WordW];
  assign out_right_score_word_o   = res_q[GainW + QUESTION_INDEX_BITS + 5*WordW +: WordW];

endmodule

>>> sim/n_best_candidate_keeper_test.sv
// n_best_candidate_keeper_test: self-checking bench for the n-best candidate keeper
// depends on nbck_pkg and n_best_candidate_keeper; a shadow list predicts every result item
// directed corner items first, then random phases at several keep_count settings
module n_best_candidate_keeper_test;
  import nbck_pkg::*;

  localparam int unsigned MaxKeep     = MaxKeepDefault;
  localparam int unsigned QBits       = QuestionBitsDflt;
  localparam int unsigned CntW        = $clog2(MaxKeep + 1);
  localparam logic [ModeW-1:0] ModeNop = 2'd3;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned DrainCycles  = 40;
  localparam int unsigned CalmFrom     = 4000;
  localparam int unsigned CalmTo       = 9000;
  localparam int unsigned IdlePct      = 7;

  typedef struct packed {
    logic [GainW-1:0] gain;
    logic [QBits-1:0] question;
    logic [WordW-1:0] left_ex;
    logic [WordW-1:0] right_ex;
    logic [WordW-1:0] left_obs;
    logic [WordW-1:0] right_obs;
    logic [WordW-1:0] left_score;
    logic [WordW-1:0] right_score;
  } candidate_t;

  typedef struct packed {
    logic             is_cfg;
    logic [KeepW-1:0] keep_value;
    logic [ModeW-1:0] mode;
    candidate_t       cand;
    logic [RidxW-1:0] read_index;
  } stim_t;

  typedef struct packed {
    logic            accepted;
    logic [CntW-1:0] held_count;
    logic            entry_valid;
    candidate_t      entry;
  } outcome_t;

  // clock, reset and block ports
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [KeepW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [ModeW-1:0] mode_i = '0;
  logic [GainW-1:0] gain_i = '0;
  logic [QBits-1:0] question_index_i = '0;
  logic [WordW-1:0] left_examples_i = '0;
  logic [WordW-1:0] right_examples_i = '0;
  logic [WordW-1:0] left_observations_i = '0;
  logic [WordW-1:0] right_observations_i = '0;
  logic [WordW-1:0] left_score_word_i = '0;
  logic [WordW-1:0] right_score_word_i = '0;
  logic [RidxW-1:0] read_index_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic accepted_o;
  logic [CntW-1:0] held_count_o;
  logic entry_valid_o;
  logic [GainW-1:0] out_gain_o;
  logic [QBits-1:0] out_question_index_o;
  logic [WordW-1:0] out_left_examples_o;
  logic [WordW-1:0] out_right_examples_o;
  logic [WordW-1:0] out_left_observations_o;
  logic [WordW-1:0] out_right_observations_o;
  logic [WordW-1:0] out_left_score_word_o;
  logic [WordW-1:0] out_right_score_word_o;

  // bench state
  stim_t       pending_items[$];
  outcome_t    expected_outcomes[$];
  candidate_t  shadow_list[MaxKeep];
  int unsigned shadow_count = 0;
  logic [KeepW-1:0] shadow_keep = 5'd1;
  int unsigned cycle_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned errors = 0;
  logic in_taken = 1'b0;

  n_best_candidate_keeper #(
    .MAX_KEEP            (MaxKeep),
    .QUESTION_INDEX_BITS (QBits)
  ) u_dut (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .cfg_we_i                 (cfg_we_i),
    .cfg_wdata_i              (cfg_wdata_i),
    .in_valid_i               (in_valid_i),
    .in_stall_o               (in_stall_o),
    .mode_i                   (mode_i),
    .gain_i                   (gain_i),
    .question_index_i         (question_index_i),
    .left_examples_i          (left_examples_i),
    .right_examples_i         (right_examples_i),
    .left_observations_i      (left_observations_i),
    .right_observations_i     (right_observations_i),
    .left_score_word_i        (left_score_word_i),
    .right_score_word_i       (right_score_word_i),
    .read_index_i             (read_index_i),
    .out_valid_o              (out_valid_o),
    .out_stall_i              (out_stall_i),
    .accepted_o               (accepted_o),
    .held_count_o             (held_count_o),
    .entry_valid_o            (entry_valid_o),
    .out_gain_o               (out_gain_o),
    .out_question_index_o     (out_question_index_o),
    .out_left_examples_o      (out_left_examples_o),
    .out_right_examples_o     (out_right_examples_o),
    .out_left_observations_o  (out_left_observations_o),
    .out_right_observations_o (out_right_observations_o),
    .out_left_score_word_o    (out_left_score_word_o),
    .out_right_score_word_o   (out_right_score_word_o)
  );

  // 10 unit clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // shadow of the sorted list: applies one item, returns its result item
  function automatic outcome_t advance_shadow_list(stim_t s);
    outcome_t    o;
    int unsigned cap;
    int unsigned pos;
    o = '0;
    cap = (shadow_keep == 0) ? 1 : ((shadow_keep > MaxKeep) ? MaxKeep : shadow_keep);
    case (s.mode)
      ModePush: begin
        if (shadow_count > cap) shadow_count = cap;
        if (shadow_count >= cap) begin
          // full list: only a strictly better gain displaces the last entry
          pos = cap - 1;
          o.accepted = s.cand.gain > shadow_list[pos].gain;
        end else begin
          pos = shadow_count;
          shadow_count++;
          o.accepted = 1'b1;
        end
        if (o.accepted) begin
          // sink past strictly smaller gains, ties keep arrival order
          while (pos > 0 && shadow_list[pos-1].gain < s.cand.gain) begin
            shadow_list[pos] = shadow_list[pos-1];
            pos--;
          end
          shadow_list[pos] = s.cand;
        end
      end
      ModeClear: shadow_count = 0;
      ModeRead: begin
        if (s.read_index < shadow_count) begin
          o.entry_valid = 1'b1;
          o.entry = shadow_list[s.read_index];
        end
      end
      default: ;
    endcase
    o.held_count = CntW'(shadow_count);
    return o;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  function automatic candidate_t random_candidate(logic [GainW-1:0] gain);
    candidate_t c;
    c.gain = gain;
    c.question = QBits'($urandom);
    c.left_ex = $urandom;
    c.right_ex = $urandom;
    c.left_obs = $urandom;
    c.right_obs = $urandom;
    c.left_score = $urandom;
    c.right_score = $urandom;
    return c;
  endfunction

  task automatic queue_item(logic [ModeW-1:0] mode, candidate_t cand, logic [RidxW-1:0] ridx);
    stim_t s;
    s = '0;
    s.mode = mode;
    s.cand = cand;
    s.read_index = ridx;
    pending_items.insert(pending_items.size(), s);
  endtask

  task automatic queue_keep_count(logic [KeepW-1:0] value);
    stim_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.keep_value = value;
    pending_items.insert(pending_items.size(), s);
  endtask

  // driver: items and register writes at the falling edge
  always @(negedge clk_i) begin : drive_items
    stim_t s;
    logic  valid_n;
    logic  we_n;
    logic  calm;
    calm = cycle_count >= CalmFrom && cycle_count < CalmTo;
    valid_n = 1'b0;
    we_n = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_taken) begin
        valid_n = 1'b1;
      end else if (pending_items.size() != 0) begin
        if (pending_items[0].is_cfg) begin
          // register writes only once the block has gone quiet
          if (quiet_cycles >= SettleCycles) begin
            s = pending_items[0];
            pending_items.delete(0);
            we_n = 1'b1;
            cfg_wdata_i <= s.keep_value;
          end
        end else if (calm || $urandom_range(0, 99) >= IdlePct) begin
          s = pending_items[0];
          pending_items.delete(0);
          valid_n = 1'b1;
          mode_i <= s.mode;
          gain_i <= s.cand.gain;
          question_index_i <= s.cand.question;
          left_examples_i <= s.cand.left_ex;
          right_examples_i <= s.cand.right_ex;
          left_observations_i <= s.cand.left_obs;
          right_observations_i <= s.cand.right_obs;
          left_score_word_i <= s.cand.left_score;
          right_score_word_i <= s.cand.right_score;
          read_index_i <= s.read_index;
        end
      end
      out_stall_i <= !calm && ($urandom_range(0, 99) < IdlePct);
    end
    in_valid_i <= valid_n;
    cfg_we_i <= we_n;
  end

  // monitor: check delivered results, then predict newly accepted items
  always @(posedge clk_i) begin : watch_ports
    stim_t    s;
    outcome_t want;
    cycle_count++;
    in_taken = rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_outcomes.size() == 0) begin
          $error("result item with no expected result pending");
          errors++;
        end else begin
          want = expected_outcomes[0];
          expected_outcomes.delete(0);
          check_field("accepted", 32'(want.accepted), 32'(accepted_o));
          check_field("held_count", 32'(want.held_count), 32'(held_count_o));
          check_field("entry_valid", 32'(want.entry_valid), 32'(entry_valid_o));
          check_field("out_gain", want.entry.gain, out_gain_o);
          check_field("out_question_index", 32'(want.entry.question),
                      32'(out_question_index_o));
          check_field("out_left_examples", want.entry.left_ex, out_left_examples_o);
          check_field("out_right_examples", want.entry.right_ex, out_right_examples_o);
          check_field("out_left_observations", want.entry.left_obs, out_left_observations_o);
          check_field("out_right_observations", want.entry.right_obs,
                      out_right_observations_o);
          check_field("out_left_score_word", want.entry.left_score, out_left_score_word_o);
          check_field("out_right_score_word", want.entry.right_score, out_right_score_word_o);
        end
      end
      // any keep_count write also empties the list
      if (cfg_we_i) begin
        shadow_keep = cfg_wdata_i;
        shadow_count = 0;
      end
      if (in_taken) begin
        s = '0;
        s.mode = mode_i;
        s.cand.gain = gain_i;
        s.cand.question = question_index_i;
        s.cand.left_ex = left_examples_i;
        s.cand.right_ex = right_examples_i;
        s.cand.left_obs = left_observations_i;
        s.cand.right_obs = right_observations_i;
        s.cand.left_score = left_score_word_i;
        s.cand.right_score = right_score_word_i;
        s.read_index = read_index_i;
        expected_outcomes.insert(expected_outcomes.size(), advance_shadow_list(s));
      end
      if (expected_outcomes.size() == 0 && !in_valid_i && !cfg_we_i) quiet_cycles++;
      else quiet_cycles = 0;
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // stimulus and end of run
  initial begin : run_stimulus
    candidate_t  cand;
    logic [KeepW-1:0] keep_settings[6];
    logic [GainW-1:0] g;
    int unsigned pick;
    keep_settings = '{5'd31, 5'd16, 5'd1, 5'd0, 5'd17, 5'd2};

    // default capacity of one: miss on empty, ties rejected, better gain replaces
    queue_item(ModeRead, random_candidate($urandom), 4'd0);
    queue_item(ModePush, random_candidate(32'd100), 4'd0);
    queue_item(ModePush, random_candidate(32'd100), 4'd0);
    queue_item(ModePush, random_candidate(32'd99), 4'd0);
    queue_item(ModePush, random_candidate(32'd101), 4'd0);
    queue_item(ModeRead, random_candidate($urandom), 4'd0);
    queue_item(ModeRead, random_candidate($urandom), 4'd1);
    queue_item(ModeNop, random_candidate($urandom), 4'd0);
    queue_item(ModeClear, random_candidate($urandom), 4'd0);
    queue_item(ModeRead, random_candidate($urandom), 4'd0);

    // capacity four: all-zero and all-one fields, equal gains in arrival order
    queue_keep_count(5'd4);
    queue_item(ModePush, '0, 4'd0);
    queue_item(ModePush, '1, 4'd15);
    queue_item(ModePush, random_candidate(32'd7), 4'd0);
    queue_item(ModePush, random_candidate(32'd7), 4'd0);
    queue_item(ModePush, random_candidate(32'd7), 4'd0);
    for (int i = 0; i < 4; i++) queue_item(ModeRead, random_candidate($urandom), i[3:0]);
    queue_item(ModeRead, random_candidate($urandom), 4'd15);
    queue_item(ModePush, random_candidate(32'd0), 4'd0);

    // zero capacity acts as one
    queue_keep_count(5'd0);
    queue_item(ModePush, random_candidate(32'd0), 4'd0);
    queue_item(ModePush, random_candidate(32'd0), 4'd0);
    queue_item(ModeRead, random_candidate($urandom), 4'd0);

    // random phases, mostly pushes and reads so lists fill and churn
    for (int ph = 0; ph < 12; ph++) begin
      queue_keep_count(ph < 6 ? keep_settings[ph] : KeepW'($urandom));
      for (int n = 0; n < 130; n++) begin
        pick = $urandom_range(0, 9);
        case (pick)
          0, 1, 2, 3: g = $urandom;
          4, 5, 6, 7: g = $urandom_range(0, 31);
          8: g = '0;
          default: g = '1;
        endcase
        cand = random_candidate(g);
        pick = $urandom_range(0, 99);
        if (pick < 60) queue_item(ModePush, cand, RidxW'($urandom));
        else if (pick < 94) queue_item(ModeRead, cand, RidxW'($urandom));
        else if (pick < 96) queue_item(ModeClear, cand, RidxW'($urandom));
        else queue_item(ModeNop, cand, RidxW'($urandom));
      end
    end

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() != 0 || in_valid_i || expected_outcomes.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_outcomes.size() != 0) begin
      $error("%0d expected results never arrived", expected_outcomes.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
